FILE: design/lzssild_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZSS decoder package
// Shared types, constants and command/status structures of the LZSS decoder.
// ----------------------------------------------------------------------------
package lzssild_pkg;

	localparam int WINDOW_BYTES_DEF = 4096;
	localparam logic [11:0] PTR_START = 12'hFEE;
	localparam logic [4:0] MIN_MATCH = 5'd3;

	typedef enum logic [1:0] {
		PH_FLAG   = 2'd0,
		PH_TOKEN  = 2'd1,
		PH_MATCH2 = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_req;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       stream_done;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic lit_emit;
		logic hold_off;
		logic set_flags;
		logic start_copy;
		logic copy_emit;
	} cmd_t;

	typedef struct packed {
		logic   fin;
		phase_t phase;
		logic   flag0;
		logic   slot_free;
		logic   copy_last;
		logic   done_next;
	} stat_t;

endpackage
`default_nettype wire

FILE: design/lzssild_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lzssild_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: design/lzssild_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZSS decoder controller
// Sequences each item through decode; a literal is emitted from decode, a match through window read and byte emission.
// ----------------------------------------------------------------------------
module lzssild_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire lzssild_pkg::stat_t  stat,
	output lzssild_pkg::cmd_t        cmd
);
	import lzssild_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DECODE = 4'b0010,
		ST_READ   = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.fin) begin
					state_d = ST_IDLE;
				end else begin
					case (stat.phase)
						PH_TOKEN: begin
							if (stat.flag0) begin
								if (stat.slot_free) begin
									cmd.lit_emit = 1'b1;
									state_d      = ST_IDLE;
								end
							end else begin
								cmd.hold_off = 1'b1;
								state_d      = ST_IDLE;
							end
						end
						PH_MATCH2: begin
							cmd.start_copy = 1'b1;
							state_d        = ST_EMIT;
						end
						default: begin
							cmd.set_flags = 1'b1;
							state_d       = ST_IDLE;
						end
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.slot_free) begin
					cmd.copy_emit = 1'b1;
					if (stat.done_next || stat.copy_last) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: design/lzssild_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZSS decoder datapath
// Token state, history window, byte counter and the output register.
// ----------------------------------------------------------------------------
module lzssild_dp #(
	parameter int WINDOW_BYTES = lzssild_pkg::WINDOW_BYTES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire lzssild_pkg::cmd_t      cmd,
	input  wire lzssild_pkg::in_item_t  in_data,
	input  wire logic                   cfg_wr_en,
	input  wire logic [31:0]            cfg_wr_data,
	output lzssild_pkg::stat_t          stat,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output lzssild_pkg::out_item_t      out_data
);
	import lzssild_pkg::*;

	localparam int AW = $clog2(WINDOW_BYTES);

	logic [7:0]    byte_q;
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   fill_q;
	logic [8:0]    flag_q;
	phase_t        phase_q;
	logic [7:0]    offlo_q;
	logic [31:0]   count_q;
	logic [31:0]   olen_q;
	logic          fin_q;
	logic [4:0]    rem_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic [AW-1:0] match_off;
	logic [AW-1:0] raddr;
	logic [AW-1:0] idx;
	logic [7:0]    rdata;
	logic [7:0]    emit_byte;
	logic [31:0]   count_inc;
	logic          emit;
	logic          done_next;
	logic          entry_valid;
	logic          consume;
	logic          slot_free;
	logic          win_we;

	assign match_off   = AW'({byte_q[7:4], offlo_q});
	assign raddr       = cmd.start_copy ? match_off : rd_q;
	assign idx         = rd_q - AW'(PTR_START);
	assign entry_valid = ({1'b0, idx} < fill_q);
	assign emit_byte   = cmd.lit_emit ? byte_q : (entry_valid ? rdata : 8'h00);
	assign count_inc   = count_q + 32'd1;
	assign done_next   = (count_inc == olen_q);
	assign emit        = cmd.lit_emit || cmd.copy_emit;
	assign consume     = emit && !done_next && (cmd.lit_emit || rem_q == 5'd1);
	assign win_we      = emit && !done_next;
	assign slot_free   = !out_valid_q || out_ready;

	lzssild_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_BYTES)
	) u_window (
		.clk  (clk),
		.we   (win_we),
		.waddr(wptr_q),
		.wdata(emit_byte),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			olen_q  <= 32'd1;
			wptr_q  <= AW'(PTR_START);
			fill_q  <= '0;
			flag_q  <= '0;
			phase_q <= PH_FLAG;
			offlo_q <= '0;
			count_q <= '0;
			fin_q   <= 1'b0;
			rem_q   <= '0;
			rd_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				olen_q <= cfg_wr_data;
			end
			if (cmd.load && in_data.start_req) begin
				wptr_q  <= AW'(PTR_START);
				fill_q  <= '0;
				flag_q  <= '0;
				phase_q <= PH_FLAG;
				offlo_q <= '0;
				count_q <= '0;
				fin_q   <= 1'b0;
			end
			if (cmd.hold_off) begin
				offlo_q <= byte_q;
				phase_q <= PH_MATCH2;
			end
			if (cmd.set_flags) begin
				flag_q  <= {1'b1, byte_q};
				phase_q <= PH_TOKEN;
			end
			if (cmd.start_copy) begin
				rem_q <= {1'b0, ~byte_q[3:0]} + MIN_MATCH;
				rd_q  <= match_off;
			end
			if (emit) begin
				count_q <= count_inc;
				if (done_next) begin
					fin_q <= 1'b1;
				end else begin
					wptr_q <= wptr_q + AW'(1);
					if (fill_q != (AW+1)'(WINDOW_BYTES)) begin
						fill_q <= fill_q + (AW+1)'(1);
					end
					if (cmd.copy_emit) begin
						rem_q <= rem_q - 5'd1;
						rd_q  <= rd_q + AW'(1);
					end
				end
			end
			if (consume) begin
				flag_q  <= {1'b0, flag_q[8:1]};
				phase_q <= (flag_q[8:2] == 7'd0) ? PH_FLAG : PH_TOKEN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= in_data.in_byte;
		end
		if (emit) begin
			out_q.out_byte    <= emit_byte;
			out_q.last_of_run <= cmd.lit_emit || done_next || rem_q == 5'd1;
			out_q.stream_done <= done_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.fin       = fin_q;
	assign stat.phase     = phase_q;
	assign stat.flag0     = flag_q[0];
	assign stat.slot_free = slot_free;
	assign stat.copy_last = (rem_q == 5'd1);
	assign stat.done_next = done_next;

endmodule
`default_nettype wire

FILE: design/lzss_inverted_length_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZSS decoder, 4 KiB window, inverted length nibble
// Takes one compressed byte per item and delivers decompressed bytes.
// ----------------------------------------------------------------------------
// Usage: compressed bytes enter on in_valid/in_ready with in_data; decoded
// bytes leave on out_valid/out_ready with out_data, one byte per item.
// The stop length is written through cfg_wr_en/cfg_wr_data while idle.
// A flag byte, a literal or the first byte of a match passes through the
// decode state. For the second byte of a match, each copied byte is read
// from the single window read port and written back before the next read.
// A literal goes from the decode state into the output register.
// A stalled receiver holds the output register and the decoder waits before
// emitting the next byte; a new item is still taken while a finished byte
// waits. Reset and start_req clear the stream state at once: a fill count
// marks which window bytes were written, and all others read as zero, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module lzss_inverted_length_decoder #(
	parameter int WINDOW_BYTES = lzssild_pkg::WINDOW_BYTES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire lzssild_pkg::in_item_t  in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output lzssild_pkg::out_item_t      out_data,
	input  wire logic                   cfg_wr_en,
	input  wire logic [31:0]            cfg_wr_data
);
	import lzssild_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lzssild_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	lzssild_dp #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_data    (in_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

`ifndef NO_ASSERTIONS
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("Item accepted while the previous one was still decoding.");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.stream_done) |-> out_data.last_of_run)
		else $error("Final byte of the stream not marked as last of its run.");

	a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.lit_emit || cmd.copy_emit) |-> stat.slot_free)
		else $error("Byte emitted while the output register was occupied.");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the LZSS decoder with inverted length nibble
// A short table of directed items is followed by randomly built compressed
// streams. A local decoder model predicts every output item, and each item
// delivered by the block is checked against the oldest prediction.
// Both sides idle at random, and the output side holds off once for a long
// stretch so that the decoder fills up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
	import lzssild_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_ITEMS = 300;
	localparam out_item_t NONE = '0;

	typedef struct {
		bit          is_cfg;
		logic [31:0] len;
		in_item_t    it;
		int          n_exp;
		out_item_t   exp;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	logic [7:0]  hist [WINDOW_BYTES_DEF];
	logic [11:0] wr_ptr;
	logic [8:0]  flags_sr;
	phase_t      phase;
	logic [7:0]  off_lo;
	logic [31:0] produced;
	bit          stream_over;
	logic [31:0] stop_len;
	logic [3:0]  far_hi;

	out_item_t   step_res [$];
	out_item_t   expected_bytes [$];
	int          errors;
	int          results_seen;
	int          idle_cycles;
	int          tx_calm;
	int          rx_calm;
	bit          held_long;

	plan_row_t plan [29] = '{
		'{1'b0, 32'd0, '{8'hFF, 1'b1}, 0, NONE},
		'{1'b0, 32'd0, '{8'h00, 1'b0}, 1, '{8'h00, 1'b1, 1'b1}},
		'{1'b0, 32'd0, '{8'h55, 1'b0}, 0, NONE},
		'{1'b1, 32'hFFFF_FFFF, '{8'h00, 1'b0}, 0, NONE},
		'{1'b0, 32'd0, '{8'h55, 1'b1}, 0, NONE},
		'{1'b0, 32'd0, '{8'hFF, 1'b0}, 1, '{8'hFF, 1'b1, 1'b0}},
		'{1'b0, 32'd0, '{8'hEE, 1'b0}, 0, NONE},
		'{1'b0, 32'd0, '{8'hFF, 1'b0}, -1, NONE},
		'{1'b0, 32'd0, '{8'h80, 1'b0}, 1, '{8'h80, 1'b1, 1'b0}},
		'{1'b0, 32'd0, '{8'h00, 1'b0}, 0, NONE},
		'{1'b0, 32'd0, '{8'hF0, 1'b0}, -1, NONE},
		'{1'b0, 32'd0, '{8'h01, 1'b0}, 1, '{8'h01, 1'b1, 1'b0}},
		'{1'b0, 32'd0, '{8'hF0, 1'b0}, 0, NONE},
		'{1'b0, 32'd0, '{8'hFF, 1'b0}, -1, NONE},
		'{1'b0, 32'd0, '{8'h7F, 1'b0}, 1, '{8'h7F, 1'b1, 1'b0}},
		'{1'b0, 32'd0, '{8'hEF, 1'b0}, 0, NONE},
		'{1'b0, 32'd0, '{8'hF8, 1'b0}, -1, NONE},
		'{1'b1, 32'd5, '{8'h00, 1'b0}, 0, NONE},
		'{1'b0, 32'd0, '{8'h00, 1'b1}, 0, NONE},
		'{1'b0, 32'd0, '{8'h00, 1'b0}, 0, NONE},
		'{1'b0, 32'd0, '{8'h0F, 1'b0}, -1, NONE},
		'{1'b0, 32'd0, '{8'h00, 1'b0}, 0, NONE},
		'{1'b0, 32'd0, '{8'h00, 1'b0}, -1, NONE},
		'{1'b0, 32'd0, '{8'hAA, 1'b0}, 0, NONE},
		'{1'b1, 32'd0, '{8'h00, 1'b0}, 0, NONE},
		'{1'b0, 32'd0, '{8'h01, 1'b1}, 0, NONE},
		'{1'b0, 32'd0, '{8'h3C, 1'b0}, 1, '{8'h3C, 1'b1, 1'b0}},
		'{1'b0, 32'd0, '{8'hFF, 1'b1}, 0, NONE},
		'{1'b0, 32'd0, '{8'hC3, 1'b0}, 1, '{8'hC3, 1'b1, 1'b0}}
	};

	lzss_inverted_length_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #4 clk = ~clk;

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(30, 150);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit emit(input logic [7:0] b);
		out_item_t r;
		produced = produced + 32'd1;
		r.out_byte = b;
		r.last_of_run = 1'b0;
		r.stream_done = (produced == stop_len);
		step_res.push_back(r);
		if (r.stream_done) begin
			stream_over = 1'b1;
		end else begin
			hist[wr_ptr] = b;
			wr_ptr = wr_ptr + 12'd1;
		end
		return r.stream_done;
	endfunction

	function automatic void next_flag();
		flags_sr = flags_sr >> 1;
		phase = (flags_sr <= 9'd1) ? PH_FLAG : PH_TOKEN;
	endfunction

	function automatic void decode_byte(input in_item_t it);
		logic [11:0] off;
		logic [11:0] rd;
		logic [3:0]  nib;
		int          len;
		bit          stop;
		out_item_t   tail;
		step_res.delete();
		if (it.start_req) begin
			foreach (hist[i])
				hist[i] = 8'h00;
			wr_ptr = PTR_START;
			flags_sr = '0;
			phase = PH_FLAG;
			off_lo = '0;
			produced = '0;
			stream_over = 1'b0;
		end
		if (stream_over)
			return;
		case (phase)
			PH_TOKEN: begin
				if (flags_sr[0]) begin
					if (!emit(it.in_byte))
						next_flag();
				end else begin
					off_lo = it.in_byte;
					phase = PH_MATCH2;
				end
			end
			PH_MATCH2: begin
				off = {it.in_byte[7:4], off_lo};
				nib = ~it.in_byte[3:0];
				len = nib + MIN_MATCH;
				stop = 1'b0;
				for (int i = 0; i < len && !stop; i++) begin
					rd = off + 12'(i);
					stop = emit(hist[rd]);
				end
				if (!stop)
					next_flag();
			end
			default: begin
				flags_sr = {1'b1, it.in_byte};
				phase = PH_TOKEN;
			end
		endcase
		if (step_res.size() > 0) begin
			tail = step_res.pop_back();
			tail.last_of_run = 1'b1;
			step_res.push_back(tail);
		end
	endfunction

	// Builds the next byte of a well-formed stream from the decoder state,
	// with matches mostly pointing a short way back into written data.
	function automatic in_item_t next_stream_byte();
		in_item_t    it;
		logic [11:0] off;
		it.start_req = 1'b0;
		it.in_byte = 8'($urandom);
		if (phase == PH_TOKEN && !flags_sr[0]) begin
			if ($urandom_range(0, 3) == 0)
				off = 12'($urandom);
			else
				off = wr_ptr - 12'($urandom_range(1, 40));
			far_hi = off[11:8];
			it.in_byte = off[7:0];
		end else if (phase == PH_MATCH2 && $urandom_range(0, 9) != 0) begin
			it.in_byte = {far_hi, 4'($urandom)};
		end
		return it;
	endfunction

	function automatic logic [31:0] pick_length();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			3: return 32'd1;
			default: return $urandom_range(2, 250);
		endcase
	endfunction

	task automatic report(input string msg);
		errors++;
		if (errors <= 50)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic send_item(input in_item_t it, input int n_exp, input out_item_t exp);
		int gap;
		gap = pick_gap(tx_calm);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		decode_byte(it);
		if (n_exp < 0) begin
			foreach (step_res[k])
				expected_bytes.push_back(step_res[k]);
		end else if (n_exp > 0) begin
			expected_bytes.push_back(exp);
		end
	endtask

	task automatic set_stop_length(input logic [31:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		stop_len = val;
	endtask

	always @(posedge clk) begin : check_out
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected item with byte %h", out_data.out_byte));
			end else begin
				want = expected_bytes.pop_front();
				if (out_data.out_byte !== want.out_byte)
					report($sformatf("out_byte %h, expected %h",
						out_data.out_byte, want.out_byte));
				if (out_data.last_of_run !== want.last_of_run)
					report($sformatf("last_of_run %b, expected %b",
						out_data.last_of_run, want.last_of_run));
				if (out_data.stream_done !== want.stream_done)
					report($sformatf("stream_done %b, expected %b",
						out_data.stream_done, want.stream_done));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin : receiver
		int stall;
		stall = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held_long && results_seen >= 100) begin
				held_long = 1'b1;
				stall = 400;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap(rx_calm);
			end
		end
	end

	initial begin : stimulus
		in_item_t it;
		int       counted;
		int       seg;
		bit       restart_next;
		bit       counts;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		errors = 0;
		results_seen = 0;
		tx_calm = 0;
		rx_calm = 0;
		held_long = 1'b0;
		far_hi = '0;
		foreach (hist[i])
			hist[i] = 8'h00;
		wr_ptr = PTR_START;
		flags_sr = '0;
		phase = PH_FLAG;
		off_lo = '0;
		produced = '0;
		stream_over = 1'b0;
		stop_len = 32'd1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				set_stop_length(plan[i].len);
			else
				send_item(plan[i].it, plan[i].n_exp, plan[i].exp);
		end

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			set_stop_length(pick_length());
			restart_next = ($urandom_range(0, 3) != 0);
			seg = 0;
			while (seg < 50 && counted < RANDOM_ITEMS) begin
				if (restart_next || (stream_over && $urandom_range(0, 4) != 0) ||
						(!stream_over && $urandom_range(0, 39) == 0)) begin
					it.in_byte = 8'($urandom);
					it.start_req = 1'b1;
				end else if (stream_over) begin
					it.in_byte = 8'($urandom);
					it.start_req = 1'b0;
				end else begin
					it = next_stream_byte();
				end
				restart_next = 1'b0;
				counts = !stream_over || it.start_req;
				send_item(it, -1, NONE);
				if (counts) begin
					seg++;
					counted++;
				end
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
design/lzssild_pkg.sv
design/lzssild_ram.sv
design/lzssild_ctrl.sv
design/lzssild_dp.sv
design/lzss_inverted_length_decoder.sv
tb/sv/testbench.sv
